// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/mtf_pkg.sv -----
// shared types and constants for the move-to-front id list
// no dependencies
package mtf_pkg;

  localparam int ID_W = 30;

  typedef enum logic [1:0] {
    MODE_TOUCH = 2'd0,
    MODE_DUMP  = 2'd1,
    MODE_CLEAR = 2'd2
  } mtf_mode_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic            touch;
    logic            clear;
    logic            rotate;
    logic [ID_W-1:0] id;
  } mtf_cell_ctl_t;

endpackage

// ----- rtl/mtf_cell.sv -----
// one slot of the move-to-front chain
// depends on mtf_pkg
module mtf_cell
  import mtf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  mtf_cell_ctl_t   ctl,
  input  logic [ID_W-1:0] up_id,
  input  logic            up_valid,
  input  logic [ID_W-1:0] dn_id,
  input  logic            dn_valid,
  input  logic [ID_W-1:0] top_id,
  input  logic            match_in,
  output logic            match_out,
  output logic [ID_W-1:0] id,
  output logic            valid
);

  logic [ID_W-1:0] id_r, id_nxt;
  logic            valid_r, valid_nxt;
  logic            match;

  assign match     = valid_r && (id_r == ctl.id);
  assign match_out = match_in | match;

  always_comb begin
    id_nxt    = id_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.touch) begin
      // shift down unless the id was found above this slot
      if (!match_in) begin
        id_nxt    = up_id;
        valid_nxt = up_valid;
      end
    end else if (ctl.rotate) begin
      // move up one; last valid slot wraps to the top entry
      if (valid_r) begin
        id_nxt = dn_valid ? dn_id : top_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r <= id_nxt;
  end

  assign id    = id_r;
  assign valid = valid_r;

endmodule

// ----- rtl/mtf_seq.sv -----
// input decode, entry count, dump sequencer and output register
// depends on mtf_pkg
module mtf_seq
  import mtf_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_mode,
  input  logic [ID_W-1:0] in_session_id,
  input  logic            hit,
  input  logic            full,
  input  logic [ID_W-1:0] top_id,
  output mtf_cell_ctl_t   ctl,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] out_entry_id,
  output logic            out_entry_valid,
  output logic            out_last_entry
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_DUMP} state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  logic            out_ev_r, out_ev_nxt;
  logic            out_last_r, out_last_nxt;
  logic            in_fire, out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;
    ctl.touch     = 1'b0;
    ctl.clear     = 1'b0;
    ctl.rotate    = 1'b0;
    ctl.id        = in_session_id;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_TOUCH: begin
              ctl.touch = 1'b1;
              if (!hit && !full) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_DUMP: begin
              state_nxt  = ST_DUMP;
              remain_nxt = count_r;
            end
            MODE_CLEAR: begin
              ctl.clear = 1'b1;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (remain_r == '0) begin
            // empty list
            out_id_nxt   = '0;
            out_ev_nxt   = 1'b0;
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            out_id_nxt   = top_id;
            out_ev_nxt   = 1'b1;
            out_last_nxt = (remain_r == CNT_W'(1));
            ctl.rotate   = 1'b1;
            remain_nxt   = remain_r - CNT_W'(1);
            if (remain_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_id_r   <= out_id_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_entry_id    = out_id_r;
  assign out_entry_valid = out_ev_r;
  assign out_last_entry  = out_last_r;

endmodule

// ----- rtl/move_to_front_id_list_top.sv -----
// top level of the move-to-front id list: a chain of id cells plus sequencer
// depends on mtf_pkg, mtf_cell, mtf_seq
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+----------------------------------------
//   in      | in  | in_valid / in_ready | in_mode, in_session_id
//   out     | out | out_valid/out_ready | out_entry_id, out_entry_valid,
//           |     |                     | out_last_entry
//
// touch and clear items may follow back to back
// a dump is accepted in idle, then emits one entry per cycle while out is free (one
//   result for an empty list), the chain rotating one position per emitted entry
// in_ready is low while a dump streams; out stalls pause the rotation
// synchronous active-low reset empties the list at once (per-cell valid bits)
module move_to_front_id_list_top
  import mtf_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_mode,
  input  logic [ID_W-1:0] in_session_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] out_entry_id,
  output logic            out_entry_valid,
  output logic            out_last_entry
);

  mtf_cell_ctl_t   ctl;
  // per-cell state taps, slot 0 is the top of the list
  logic [ID_W-1:0] id_w    [LIST_DEPTH];
  logic            vld_w   [LIST_DEPTH];
  // running "found above or here" flag down the chain
  logic            mch_w   [LIST_DEPTH];
  logic            hit, full;

  assign hit  = mch_w[LIST_DEPTH-1];
  assign full = vld_w[LIST_DEPTH-1];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] up_id, dn_id;
    logic            up_valid, dn_valid, m_in;

    if (i == 0) begin : g_first
      // the touched id enters at the top
      assign up_id    = ctl.id;
      assign up_valid = 1'b1;
      assign m_in     = 1'b0;
    end else begin : g_mid
      assign up_id    = id_w[i-1];
      assign up_valid = vld_w[i-1];
      assign m_in     = mch_w[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      // bottom entry falls off on a touch into a full list
      assign dn_id    = '0;
      assign dn_valid = 1'b0;
    end else begin : g_inner
      assign dn_id    = id_w[i+1];
      assign dn_valid = vld_w[i+1];
    end

    mtf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .up_id     (up_id),
      .up_valid  (up_valid),
      .dn_id     (dn_id),
      .dn_valid  (dn_valid),
      .top_id    (id_w[0]),
      .match_in  (m_in),
      .match_out (mch_w[i]),
      .id        (id_w[i]),
      .valid     (vld_w[i])
    );
  end

  // decode, count, dump stream and output register
  mtf_seq #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_session_id   (in_session_id),
    .hit             (hit),
    .full            (full),
    .top_id          (id_w[0]),
    .ctl             (ctl),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_id    (out_entry_id),
    .out_entry_valid (out_entry_valid),
    .out_last_entry  (out_last_entry)
  );

endmodule

// ----- rtl/mtf_checker.sv -----
// port-level checks for the move-to-front id list, bound to the top level
// depends on mtf_pkg and assert_macros.svh
`include "assert_macros.svh"

module mtf_checker
  import mtf_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic [1:0]      in_mode,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ID_W-1:0] out_entry_id,
  input logic            out_entry_valid,
  input logic            out_last_entry
);

  // a stalled transfer holds its entry id and last flag
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_entry_id) && $stable(out_last_entry))

  // the empty-list result is always the last of its dump
  `ASSERT_SAME(a_empty_last, out_valid && !out_entry_valid, out_last_entry)

  // the empty-list result carries a zero id
  `ASSERT_SAME(a_empty_zero, out_valid && !out_entry_valid, out_entry_id == '0)

  // an accepted dump blocks further input while it streams
  `ASSERT_NEXT(a_dump_busy, in_valid && in_ready && in_mode == MODE_DUMP, !in_ready)

endmodule

bind move_to_front_id_list_top mtf_checker u_mtf_checker (.*);
